// File: rtl/core/prp_pkg.sv
// Shared types and constants for the page replacement policy block.
`default_nettype none
package prp_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_LRU,
        ST_CLOCK,
        ST_WRITE
    } state_t;

    // Victim policy codes (the unused code behaves as FIFO)
    localparam logic [1:0] MODE_FIFO  = 2'd0;
    localparam logic [1:0] MODE_LRU   = 2'd1;
    localparam logic [1:0] MODE_CLOCK = 2'd2;

    // Register index, taken from paddr[2]
    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_FRAMES = 1'b1;

    // Fixed field widths
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;
    localparam int MODE_W        = 2;
    localparam int FRAMES_CFG_W  = 5;
    localparam int FRAME_OUT_W   = 4;
    localparam int FAULT_W       = 32;

    // Reset value of the frame count register
    localparam logic [FRAMES_CFG_W-1:0] FRAMES_CFG_RESET = 5'd16;

endpackage
`default_nettype wire

// File: rtl/core/page_replacement_policy.sv
// Page replacement policy: frame search with FIFO, LRU and Clock victim selection.
//
// Input channel (s_valid/s_ready/s_page_number): one page reference per beat.
// Result channel (m_valid/m_ready/m_hit/m_frame_index/m_fault_total): one
// result beat per reference, in order.
// APB-style port: register 0 (addr 0) replacement_mode, register 1 (addr 4)
// frames_in_use. Write only while the block is idle. pready is tied high.
//
// One reference at a time goes through a small sequencer built around one
// frame memory read port and one stamp comparator. Its steps, in order:
//   search (pipelined reads, ends early on a hit),
//   LRU victim scan or Clock sweep on a miss (FIFO needs no scan),
//   update and result load.
// s_ready is high only between references; a result waiting in the output
// register does not block the next reference, but the sequencer holds in
// its update step while the previous result is still unaccepted.
// Reset (aresetn low, synchronous) empties all frames, clears the reference
// bits, pointers and fault count, and sets the use counter to 1.
`default_nettype none
module page_replacement_policy #(
    parameter int FRAMES     = 16,
    parameter int PAGE_BITS  = 20,
    parameter int STAMP_BITS = 32
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    // config port
    input  wire                                   psel,
    input  wire                                   penable,
    input  wire                                   pwrite,
    input  wire  [prp_pkg::ADDR_W-1:0]            paddr,
    input  wire  [prp_pkg::DATA_W-1:0]            pwdata,
    output logic [prp_pkg::DATA_W-1:0]            prdata,
    output logic                                  pready,
    // reference channel
    input  wire                                   s_valid,
    output logic                                  s_ready,
    input  wire  [PAGE_BITS-1:0]                  s_page_number,
    // result channel
    output logic                                  m_valid,
    input  wire                                   m_ready,
    output logic                                  m_hit,
    output logic [prp_pkg::FRAME_OUT_W-1:0]       m_frame_index,
    output logic [prp_pkg::FAULT_W-1:0]           m_fault_total
);

    localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W  = FIDX_W + 1;

    // config registers
    logic [prp_pkg::MODE_W-1:0]       mode_reg;
    logic [prp_pkg::FRAMES_CFG_W-1:0] fiu_reg;

    // sequencer and datapath registers
    prp_pkg::state_t       state_reg, state_next;
    logic [PAGE_BITS-1:0]  page_reg, page_next;
    logic                  hit_reg, hit_next;
    logic [FIDX_W-1:0]     frame_reg, frame_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  rd_ok_reg, rd_ok_next;
    logic [FIDX_W-1:0]     rd_idx_reg;
    logic [PAGE_BITS-1:0]  rd_page_reg;
    logic [STAMP_BITS-1:0] rd_stamp_reg;
    logic [FIDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [STAMP_BITS-1:0] best_stamp_reg, best_stamp_next;
    logic [FIDX_W-1:0]     fifo_ptr_reg, fifo_ptr_next;
    logic [FIDX_W-1:0]     sweep_ptr_reg, sweep_ptr_next;
    logic [STAMP_BITS-1:0] use_cnt_reg, use_cnt_next;
    logic [prp_pkg::FAULT_W-1:0] fault_reg, fault_next;
    logic [FRAMES-1:0]     valid_reg, valid_next;
    logic [FRAMES-1:0]     sc_reg, sc_next;

    // output registers
    logic                           m_valid_reg, m_valid_next;
    logic                           m_hit_reg;
    logic [prp_pkg::FRAME_OUT_W-1:0] m_frame_reg;
    logic [prp_pkg::FAULT_W-1:0]    m_fault_reg;

    // frame memories
    logic [PAGE_BITS-1:0]  page_mem  [FRAMES];
    logic [STAMP_BITS-1:0] stamp_mem [FRAMES];

    logic                  issue;
    logic                  commit;
    logic [31:0]           fiu_w;
    logic [31:0]           n_w;
    logic [CNT_W-1:0]      n;
    logic [CNT_W-1:0]      n_last;
    logic                  rd_last;
    logic                  rd_match;
    logic [STAMP_BITS-1:0] st_eff;
    logic                  take;
    logic [FIDX_W-1:0]     win_idx;
    logic [STAMP_BITS-1:0] win_stamp;
    logic [CNT_W-1:0]      fifo_start;
    logic [CNT_W-1:0]      sweep_start;
    logic [CNT_W-1:0]      fifo_inc;
    logic [CNT_W-1:0]      clk_inc;
    logic [FIDX_W-1:0]     clk_p;
    logic [31:0]           frame_w;
    logic                  cfg_wr;

    // active frame count, clamped to 1..FRAMES
    always_comb begin
        fiu_w = {{(32-prp_pkg::FRAMES_CFG_W){1'b0}}, fiu_reg};
        if (fiu_w == 32'd0) begin
            n_w = 32'd1;
        end else if (fiu_w > 32'(FRAMES)) begin
            n_w = 32'(FRAMES);
        end else begin
            n_w = fiu_w;
        end
        n      = n_w[CNT_W-1:0];
        n_last = n - 1'b1;
    end

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[2])
            prp_pkg::REG_MODE:   prdata = {{(prp_pkg::DATA_W-prp_pkg::MODE_W){1'b0}}, mode_reg};
            prp_pkg::REG_FRAMES: prdata = {{(prp_pkg::DATA_W-prp_pkg::FRAMES_CFG_W){1'b0}},
                                           fiu_reg};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= prp_pkg::MODE_FIFO;
            fiu_reg  <= prp_pkg::FRAMES_CFG_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == prp_pkg::REG_MODE) begin
                mode_reg <= pwdata[prp_pkg::MODE_W-1:0];
            end else begin
                fiu_reg <= pwdata[prp_pkg::FRAMES_CFG_W-1:0];
            end
        end
    end

    // handshake
    assign s_ready       = (state_reg == prp_pkg::ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_hit         = m_hit_reg;
    assign m_frame_index = m_frame_reg;
    assign m_fault_total = m_fault_reg;

    // scan helpers: the one shared compare unit
    always_comb begin
        rd_last   = ({1'b0, rd_idx_reg} == n_last);
        rd_match  = valid_reg[rd_idx_reg] && (rd_page_reg == page_reg);
        st_eff    = valid_reg[rd_idx_reg] ? rd_stamp_reg : '0;
        take      = (rd_idx_reg == '0) || (st_eff < best_stamp_reg);
        win_idx   = take ? rd_idx_reg : best_idx_reg;
        win_stamp = take ? st_eff : best_stamp_reg;
        fifo_start  = ({1'b0, fifo_ptr_reg} < n) ? {1'b0, fifo_ptr_reg} : '0;
        sweep_start = ({1'b0, sweep_ptr_reg} < n) ? {1'b0, sweep_ptr_reg} : '0;
        fifo_inc    = ((fifo_start + 1'b1) == n) ? '0 : fifo_start + 1'b1;
        clk_p       = cnt_reg[FIDX_W-1:0];
        clk_inc     = (({1'b0, clk_p} + 1'b1) == n) ? '0 : {1'b0, clk_p} + 1'b1;
        frame_w     = {{(32-FIDX_W){1'b0}}, frame_reg};
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        page_next       = page_reg;
        hit_next        = hit_reg;
        frame_next      = frame_reg;
        cnt_next        = cnt_reg;
        rd_ok_next      = 1'b0;
        best_idx_next   = best_idx_reg;
        best_stamp_next = best_stamp_reg;
        fifo_ptr_next   = fifo_ptr_reg;
        sweep_ptr_next  = sweep_ptr_reg;
        use_cnt_next    = use_cnt_reg;
        fault_next      = fault_reg;
        valid_next      = valid_reg;
        sc_next         = sc_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        issue           = 1'b0;
        commit          = 1'b0;

        unique case (state_reg)
            prp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    page_next  = s_page_number;
                    cnt_next   = '0;
                    state_next = prp_pkg::ST_SEARCH;
                end
            end

            prp_pkg::ST_SEARCH: begin
                issue      = (cnt_reg < n);
                rd_ok_next = issue;
                if (issue) begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (rd_ok_reg && rd_match) begin
                    hit_next   = 1'b1;
                    frame_next = rd_idx_reg;
                    rd_ok_next = 1'b0;
                    state_next = prp_pkg::ST_WRITE;
                end else if (rd_ok_reg && rd_last) begin
                    // page fault: count it and pick a victim
                    hit_next   = 1'b0;
                    rd_ok_next = 1'b0;
                    if (fault_reg != '1) begin
                        fault_next = fault_reg + 1'b1;
                    end
                    case (mode_reg)
                        prp_pkg::MODE_LRU: begin
                            cnt_next   = '0;
                            state_next = prp_pkg::ST_LRU;
                        end
                        prp_pkg::MODE_CLOCK: begin
                            cnt_next   = sweep_start;
                            state_next = prp_pkg::ST_CLOCK;
                        end
                        default: begin
                            frame_next    = fifo_start[FIDX_W-1:0];
                            fifo_ptr_next = fifo_inc[FIDX_W-1:0];
                            state_next    = prp_pkg::ST_WRITE;
                        end
                    endcase
                end
            end

            prp_pkg::ST_LRU: begin
                issue      = (cnt_reg < n);
                rd_ok_next = issue;
                if (issue) begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (rd_ok_reg) begin
                    best_idx_next   = win_idx;
                    best_stamp_next = win_stamp;
                    if (rd_last) begin
                        frame_next = win_idx;
                        rd_ok_next = 1'b0;
                        state_next = prp_pkg::ST_WRITE;
                    end
                end
            end

            prp_pkg::ST_CLOCK: begin
                // second chance: clear set bits until a clear one is found
                if (!sc_reg[clk_p]) begin
                    frame_next     = clk_p;
                    sweep_ptr_next = clk_inc[FIDX_W-1:0];
                    state_next     = prp_pkg::ST_WRITE;
                end else begin
                    sc_next[clk_p] = 1'b0;
                    cnt_next       = clk_inc;
                end
            end

            prp_pkg::ST_WRITE: begin
                if (!m_valid_reg || m_ready) begin
                    commit            = 1'b1;
                    valid_next[frame_reg] = 1'b1;
                    sc_next[frame_reg]    = 1'b1;
                    use_cnt_next      = use_cnt_reg + 1'b1;
                    m_valid_next      = 1'b1;
                    state_next        = prp_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = prp_pkg::ST_IDLE;
            end
        endcase
    end

    // state register and control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= prp_pkg::ST_IDLE;
            rd_ok_reg     <= 1'b0;
            fifo_ptr_reg  <= '0;
            sweep_ptr_reg <= '0;
            use_cnt_reg   <= {{(STAMP_BITS-1){1'b0}}, 1'b1};
            fault_reg     <= '0;
            valid_reg     <= '0;
            sc_reg        <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rd_ok_reg     <= rd_ok_next;
            fifo_ptr_reg  <= fifo_ptr_next;
            sweep_ptr_reg <= sweep_ptr_next;
            use_cnt_reg   <= use_cnt_next;
            fault_reg     <= fault_next;
            valid_reg     <= valid_next;
            sc_reg        <= sc_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        page_reg       <= page_next;
        hit_reg        <= hit_next;
        frame_reg      <= frame_next;
        cnt_reg        <= cnt_next;
        best_idx_reg   <= best_idx_next;
        best_stamp_reg <= best_stamp_next;
        if (commit) begin
            m_hit_reg   <= hit_reg;
            m_frame_reg <= frame_w[prp_pkg::FRAME_OUT_W-1:0];
            m_fault_reg <= fault_reg;
        end
    end

    // frame page and stamp memories, one registered read port
    always_ff @(posedge aclk) begin
        if (commit) begin
            page_mem[frame_reg]  <= page_reg;
            stamp_mem[frame_reg] <= use_cnt_reg;
        end
        if (issue) begin
            rd_page_reg  <= page_mem[cnt_reg[FIDX_W-1:0]];
            rd_stamp_reg <= stamp_mem[cnt_reg[FIDX_W-1:0]];
            rd_idx_reg   <= cnt_reg[FIDX_W-1:0];
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/prp_checker.sv
// Port-level checks for the page replacement policy block, bound to the top level.
`default_nettype none
module prp_checker (
    input wire                                aclk,
    input wire                                aresetn,
    input wire                                pready,
    input wire                                s_valid,
    input wire                                s_ready,
    input wire                                m_valid,
    input wire                                m_ready,
    input wire                                m_hit,
    input wire [prp_pkg::FRAME_OUT_W-1:0]     m_frame_index,
    input wire [prp_pkg::FAULT_W-1:0]         m_fault_total
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_frame_index)
            && $stable(m_fault_total))
        else $error("result beat changed while stalled");

    // one reference at a time: busy right after an accepted beat
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a reference is in work");

    // a miss has always counted at least one fault
    a_miss_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_fault_total != '0)
        else $error("miss reported with zero fault count");

    // reset drops any result
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // config port never waits
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind page_replacement_policy prp_checker u_prp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .pready        (pready),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_hit         (m_hit),
    .m_frame_index (m_frame_index),
    .m_fault_total (m_fault_total)
);
`default_nettype wire
